>>> rtl/core/csid_pkg.sv
package csid_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned LenWidth   = 3;

   // Encoded lengths in bytes
   localparam logic [LenWidth-1:0] LEN_ONE  = 3'd1;
   localparam logic [LenWidth-1:0] LEN_TWO  = 3'd2;
   localparam logic [LenWidth-1:0] LEN_FOUR = 3'd4;
   localparam logic [LenWidth-1:0] LEN_FIVE = 3'd5;

   // Payload masks applied to the header byte
   localparam logic [ByteWidth-1:0] KEEP_LOW4     = 8'h0F;  // signed 4-byte negative
   localparam logic [ByteWidth-1:0] KEEP_LOW6     = 8'h3F;  // 4-byte form
   localparam logic [ByteWidth-1:0] KEEP_NO_A0    = 8'h5F;  // signed 2-byte negative
   localparam logic [ByteWidth-1:0] KEEP_LOW7     = 8'h7F;  // 2-byte form
   localparam logic [ByteWidth-1:0] KEEP_NO_40    = 8'hBF;  // signed 1-byte negative

   // Unsigned header codes (top three bits)
   localparam logic [2:0] UHDR_FIVE  = 3'b111;
   localparam logic [2:0] UHDR_FOUR  = 3'b110;
   localparam logic [2:0] UHDR_TWO_A = 3'b101;
   localparam logic [2:0] UHDR_TWO_B = 3'b100;

   // Signed header codes (top four bits)
   localparam logic [3:0] SHDR_FIVE_NEG = 4'hF;
   localparam logic [3:0] SHDR_FIVE_POS = 4'hE;
   localparam logic [3:0] SHDR_FOUR_NEG = 4'hD;
   localparam logic [3:0] SHDR_FOUR_POS = 4'hC;
   localparam logic [3:0] SHDR_TWO_NEG1 = 4'hB;
   localparam logic [3:0] SHDR_TWO_NEG0 = 4'hA;
   localparam logic [3:0] SHDR_TWO_POS1 = 4'h9;
   localparam logic [3:0] SHDR_TWO_POS0 = 4'h8;
   localparam logic [3:0] SHDR_ONE_NEG3 = 4'h7;
   localparam logic [3:0] SHDR_ONE_NEG2 = 4'h6;
   localparam logic [3:0] SHDR_ONE_NEG1 = 4'h5;
   localparam logic [3:0] SHDR_ONE_NEG0 = 4'h4;

   // Header decode result
   typedef struct packed {
      logic [LenWidth-1:0]  length;
      logic [ByteWidth-1:0] payload;
      logic                 negate;
   } hdr_info_type;

   // Decoder status seen by the top level
   typedef struct packed {
      logic                busy;
      logic [LenWidth-1:0] remaining;
   } step_status_type;

endpackage

>>> rtl/core/compact_int_stream_decoder_core.sv
// Compact integer stream decoder.
// Request channel: one byte of the stream per request (req_data_byte) with
// req_signed_kind, which selects the signed encoding and matters only on the
// first byte of an integer. Result channel: one decoded 32-bit value
// (rsp_value, two's complement when signed) plus its encoded length in bytes
// (1, 2, 4 or 5) for each complete integer; bytes that do not finish an
// integer give no result.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Throughput: one byte per cycle while req_stall is low. The last byte of an
// integer passes from the input register through the header decode /
// shift-accumulate step into the result register, which drives rsp_valid.
// When the receiver stalls, the result register holds and the input register
// fills; req_stall rises only when both are occupied.
// Reset (synchronous, active high) empties both registers and returns the
// decoder to waiting for a header byte; a partial integer is dropped.
module compact_int_stream_decoder_core
   import csid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ByteWidth-1:0]  req_data_byte,
   input  logic                  req_signed_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ValueWidth-1:0] rsp_value,
   output logic [LenWidth-1:0]   rsp_encoded_length
);

   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_signed_ff;
   logic                  out_valid_ff;
   logic [ValueWidth-1:0] out_value_ff;
   logic [LenWidth-1:0]   out_length_ff;
   logic                  out_free;
   logic                  in_free;
   logic                  step_en;
   logic                  step_done;
   logic [ValueWidth-1:0] step_value;
   logic [LenWidth-1:0]   step_length;
   step_status_type       step_status;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;

   // Capture the request byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
      if (in_free && req_valid) begin
         in_byte_ff   <= req_data_byte;
         in_signed_ff <= req_signed_kind;
      end
   end

   csid_step u_step (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .data_byte   (in_byte_ff),
      .signed_kind (in_signed_ff),
      .done        (step_done),
      .value       (step_value),
      .length      (step_length),
      .status      (step_status)
   );

   // Load the result register; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step_en && step_done;
      end
      if (step_en && step_done) begin
         out_value_ff  <= step_value;
         out_length_ff <= step_length;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_value_ff;
   assign rsp_encoded_length = out_length_ff;

   // Delivered lengths are only the encodable ones
   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_encoded_length == LEN_ONE || rsp_encoded_length == LEN_TWO ||
                     rsp_encoded_length == LEN_FOUR || rsp_encoded_length == LEN_FIVE))
      else $error("illegal encoded length on result");

   // No integer ever needs more than four continuation bytes
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      step_status.remaining <= 3'd4)
      else $error("remaining byte count out of range");

   // A byte that does not finish an integer leaves the decoder busy
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (step_en && !step_done) |=> step_status.busy)
      else $error("decoder idle after a non-final byte");

   // A finished integer leaves the decoder waiting for a header
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      (step_en && step_done) |=> !step_status.busy)
      else $error("decoder busy after a final byte");

   // Both registers are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

>>> rtl/core/csid_hdr_decode.sv
module csid_hdr_decode
   import csid_pkg::*;
(
   input  logic [ByteWidth-1:0] data_byte,
   input  logic                 signed_kind,
   output hdr_info_type         hdr_info
);

   // Classify the header byte: length, payload bits and sign
   always_comb begin
      hdr_info = '{length: LEN_ONE, payload: data_byte, negate: 1'b0};
      if (!signed_kind) begin
         unique case (data_byte[7:5])
            UHDR_FIVE: begin
               hdr_info.length  = LEN_FIVE;
               hdr_info.payload = '0;
            end
            UHDR_FOUR: begin
               hdr_info.length  = LEN_FOUR;
               hdr_info.payload = data_byte & KEEP_LOW6;
            end
            UHDR_TWO_A, UHDR_TWO_B: begin
               hdr_info.length  = LEN_TWO;
               hdr_info.payload = data_byte & KEEP_LOW7;
            end
            default: begin
               hdr_info.length  = LEN_ONE;
               hdr_info.payload = data_byte;
            end
         endcase
      end else begin
         unique case (data_byte[7:4])
            SHDR_FIVE_NEG, SHDR_FIVE_POS: begin
               hdr_info.length  = LEN_FIVE;
               hdr_info.payload = '0;
               hdr_info.negate  = (data_byte[7:4] == SHDR_FIVE_NEG);
            end
            SHDR_FOUR_NEG: begin
               hdr_info.length  = LEN_FOUR;
               hdr_info.payload = data_byte & KEEP_LOW4;
               hdr_info.negate  = 1'b1;
            end
            SHDR_FOUR_POS: begin
               hdr_info.length  = LEN_FOUR;
               hdr_info.payload = data_byte & KEEP_LOW6;
            end
            SHDR_TWO_NEG1, SHDR_TWO_NEG0: begin
               hdr_info.length  = LEN_TWO;
               hdr_info.payload = data_byte & KEEP_NO_A0;
               hdr_info.negate  = 1'b1;
            end
            SHDR_TWO_POS1, SHDR_TWO_POS0: begin
               hdr_info.length  = LEN_TWO;
               hdr_info.payload = data_byte & KEEP_LOW7;
            end
            SHDR_ONE_NEG3, SHDR_ONE_NEG2, SHDR_ONE_NEG1, SHDR_ONE_NEG0: begin
               hdr_info.length  = LEN_ONE;
               hdr_info.payload = data_byte & KEEP_NO_40;
               hdr_info.negate  = 1'b1;
            end
            default: begin
               hdr_info.length  = LEN_ONE;
               hdr_info.payload = data_byte;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/csid_step.sv
module csid_step
   import csid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [ByteWidth-1:0]  data_byte,
   input  logic                  signed_kind,
   output logic                  done,
   output logic [ValueWidth-1:0] value,
   output logic [LenWidth-1:0]   length,
   output step_status_type       status
);

   logic [LenWidth-1:0]   remaining_ff, remaining_in;
   logic [ValueWidth-1:0] accum_ff, accum_in, accum_full;
   logic                  negate_ff, negate_in, negate_full;
   logic [LenWidth-1:0]   total_ff, total_in, total_full;
   hdr_info_type          hdr_info;

   csid_hdr_decode u_hdr_decode (
      .data_byte   (data_byte),
      .signed_kind (signed_kind),
      .hdr_info    (hdr_info)
   );

   // Advance the integer in progress by one byte
   always_comb begin
      if (remaining_ff != '0) begin
         accum_full   = {accum_ff[ValueWidth-ByteWidth-1:0], data_byte};
         negate_full  = negate_ff;
         total_full   = total_ff;
         remaining_in = remaining_ff - 1'b1;
      end else begin
         accum_full   = {{(ValueWidth-ByteWidth){1'b0}}, hdr_info.payload};
         negate_full  = hdr_info.negate;
         total_full   = hdr_info.length;
         remaining_in = hdr_info.length - 1'b1;
      end
      done   = (remaining_in == '0);
      value  = negate_full ? (~accum_full + 1'b1) : accum_full;
      length = total_full;
      // Clear the context once the integer completes
      accum_in  = done ? '0   : accum_full;
      negate_in = done ? 1'b0 : negate_full;
      total_in  = done ? '0   : total_full;
   end

   // Hold decoder context
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         accum_ff     <= '0;
         negate_ff    <= 1'b0;
         total_ff     <= '0;
      end else if (step_en) begin
         remaining_ff <= remaining_in;
         accum_ff     <= accum_in;
         negate_ff    <= negate_in;
         total_ff     <= total_in;
      end
   end

   assign status = '{busy: (remaining_ff != '0), remaining: remaining_ff};

endmodule

>>> dv/tb_top.sv
module tb_top;
   import csid_pkg::*;

   localparam int IdleLimit    = 4000;
   localparam int DrainCycles  = 8;
   localparam int RandomBytes  = 1200;
   localparam int MaxReported  = 10;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 sgn;
   } stream_byte_t;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic [LenWidth-1:0]   length;
   } decoded_int_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ByteWidth-1:0]  req_data_byte;
   logic                  req_signed_kind;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ValueWidth-1:0] rsp_value;
   logic [LenWidth-1:0]   rsp_encoded_length;

   stream_byte_t pending_bytes[$];
   decoded_int_t expected_ints[$];

   // decoder shadow state
   logic [LenWidth-1:0]   dec_remaining;
   logic [ValueWidth-1:0] dec_acc;
   logic                  dec_negate;
   logic [LenWidth-1:0]   dec_total;

   int   total_bytes;
   int   accepted_bytes;
   int   mismatches;
   int   idle_cycles;
   logic req_taken;
   int   burst_left;
   int   gap_left;
   int   stall_left;
   int   stall_mode;

   compact_int_stream_decoder_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_signed_kind    (req_signed_kind),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_encoded_length (rsp_encoded_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Split a header byte into length, payload bits and negate flag
   function automatic hdr_info_type header_decode(input logic [ByteWidth-1:0] b,
                                                  input logic sgn);
      hdr_info_type info;
      info = '{length: LEN_ONE, payload: b, negate: 1'b0};
      if (!sgn) begin
         case (b[7:5])
            UHDR_FIVE: begin
               info.length  = LEN_FIVE;
               info.payload = '0;
            end
            UHDR_FOUR: begin
               info.length  = LEN_FOUR;
               info.payload = b & KEEP_LOW6;
            end
            UHDR_TWO_A, UHDR_TWO_B: begin
               info.length  = LEN_TWO;
               info.payload = b & KEEP_LOW7;
            end
            default: ;
         endcase
      end else begin
         case (b[7:4])
            SHDR_FIVE_NEG, SHDR_FIVE_POS: begin
               info.length  = LEN_FIVE;
               info.payload = '0;
               info.negate  = (b[7:4] == SHDR_FIVE_NEG);
            end
            SHDR_FOUR_NEG: begin
               info.length  = LEN_FOUR;
               info.payload = b & KEEP_LOW4;
               info.negate  = 1'b1;
            end
            SHDR_FOUR_POS: begin
               info.length  = LEN_FOUR;
               info.payload = b & KEEP_LOW6;
            end
            SHDR_TWO_NEG1, SHDR_TWO_NEG0: begin
               info.length  = LEN_TWO;
               info.payload = b & KEEP_NO_A0;
               info.negate  = 1'b1;
            end
            SHDR_TWO_POS1, SHDR_TWO_POS0: begin
               info.length  = LEN_TWO;
               info.payload = b & KEEP_LOW7;
            end
            SHDR_ONE_NEG3, SHDR_ONE_NEG2, SHDR_ONE_NEG1, SHDR_ONE_NEG0: begin
               info.payload = b & KEEP_NO_40;
               info.negate  = 1'b1;
            end
            default: ;
         endcase
      end
      return info;
   endfunction

   // Advance the shadow decoder by one byte; queue a value when one completes
   task automatic decode_byte(input logic [ByteWidth-1:0] b, input logic sgn);
      hdr_info_type info;
      decoded_int_t done;
      if (dec_remaining != 0) begin
         dec_acc       = {dec_acc[ValueWidth-ByteWidth-1:0], b};
         dec_remaining = dec_remaining - 1'b1;
      end else begin
         info          = header_decode(b, sgn);
         dec_total     = info.length;
         dec_acc       = {{(ValueWidth-ByteWidth){1'b0}}, info.payload};
         dec_negate    = info.negate;
         dec_remaining = info.length - 1'b1;
      end
      if (dec_remaining == 0) begin
         done.value  = dec_negate ? (32'd0 - dec_acc) : dec_acc;
         done.length = dec_total;
         expected_ints.push_back(done);
         dec_acc    = '0;
         dec_negate = 1'b0;
         dec_total  = '0;
      end
   endtask

   // Queue one integer: header, then its continuation bytes big-endian.
   // Continuation bytes carry a random signed flag, which must be ignored.
   task automatic add_int(input logic sgn, input logic [ByteWidth-1:0] hdr,
                          input logic [ValueWidth-1:0] tail);
      hdr_info_type info;
      info = header_decode(hdr, sgn);
      pending_bytes.push_back('{data: hdr, sgn: sgn});
      for (int i = int'(info.length) - 1; i >= 1; i--)
         pending_bytes.push_back('{data: tail[8*(i-1) +: 8], sgn: 1'($urandom_range(0, 1))});
   endtask

   task automatic build_directed();
      // unsigned single-byte extremes and two-byte forms
      add_int(1'b0, 8'h00, 32'h0);
      add_int(1'b0, 8'h7F, 32'h0);
      add_int(1'b0, 8'h80, 32'h00);
      add_int(1'b0, 8'hBF, 32'hFF);
      add_int(1'b0, 8'h9A, 32'h5A);
      // unsigned four and five bytes
      add_int(1'b0, 8'hC0, 32'h000000);
      add_int(1'b0, 8'hDF, 32'hFFFFFF);
      add_int(1'b0, 8'hE0, 32'h00000000);
      add_int(1'b0, 8'hFF, 32'hFFFFFFFF);
      // signed single byte: positive, negative, negative zero; then a five-byte negative
      add_int(1'b1, 8'h3F, 32'h0);
      add_int(1'b1, 8'h40, 32'h0);
      add_int(1'b1, 8'h7F, 32'h0);
      add_int(1'b1, 8'hFF, 32'h00000001);
      // signed two bytes, high bits left over in the value
      add_int(1'b1, 8'hB5, 32'hC3);
      add_int(1'b1, 8'hA0, 32'h01);
      add_int(1'b1, 8'h9F, 32'hFF);
      add_int(1'b1, 8'h80, 32'h00);
      // signed four bytes
      add_int(1'b1, 8'hDF, 32'hFFFFFF);
      add_int(1'b1, 8'hCF, 32'h123456);
      // signed five bytes, most negative wraps onto itself
      add_int(1'b1, 8'hF0, 32'h80000000);
      add_int(1'b1, 8'hE3, 32'h7FFFFFFF);
      add_int(1'b1, 8'hF7, 32'h00000000);
      // mode flips on the byte right after a completed integer
      add_int(1'b0, 8'hC1, 32'hA5A5A5);
      add_int(1'b1, 8'hD2, 32'h5A5A5A);
   endtask

   task automatic build_random();
      logic [ValueWidth-1:0] tail;
      logic [ByteWidth-1:0]  hdr;
      int                    pick;
      while (pending_bytes.size() < total_bytes + RandomBytes) begin
         pick = $urandom_range(0, 7);
         hdr  = 8'($urandom_range(0, 255));
         tail = $urandom;
         if (pick == 0)
            tail = '0;
         else if (pick == 1)
            tail = '1;
         add_int(1'($urandom_range(0, 1)), hdr, tail);
      end
   endtask

   // Track accepted requests and feed the shadow decoder
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data_byte, req_signed_kind);
         accepted_bytes <= accepted_bytes + 1;
         req_taken      <= 1'b1;
      end
   end

   // Drive requests in bursts separated by random gaps
   always @(negedge clock) begin
      stream_byte_t item;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken <= 1'b0;
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            item = pending_bytes.pop_front();
            req_valid       <= 1'b1;
            req_data_byte   <= item.data;
            req_signed_kind <= item.sgn;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side in phases of varying density
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left <= $urandom_range(1, 40);
         stall_mode <= $urandom_range(0, 3);
         rsp_stall  <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Compare each accepted result against the oldest expected value
   always @(posedge clock) begin
      decoded_int_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ints.size() == 0) begin
            if (mismatches < MaxReported)
               $display("unexpected result: value=%h length=%0d",
                        rsp_value, rsp_encoded_length);
            mismatches <= mismatches + 1;
         end else begin
            want = expected_ints.pop_front();
            if (rsp_value !== want.value || rsp_encoded_length !== want.length) begin
               if (mismatches < MaxReported)
                  $display("mismatch: expected value=%h length=%0d, got value=%h length=%0d",
                           want.value, want.length, rsp_value, rsp_encoded_length);
               mismatches <= mismatches + 1;
            end
         end
      end
   end

   // Count cycles in which neither channel completes a transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = '0;
      req_signed_kind = 1'b0;
      rsp_stall       = 1'b0;
      req_taken       = 1'b0;
      dec_remaining   = '0;
      dec_acc         = '0;
      dec_negate      = 1'b0;
      dec_total       = '0;
      accepted_bytes  = 0;
      mismatches      = 0;
      idle_cycles     = 0;
      burst_left      = 1;
      gap_left        = 0;
      stall_left      = 0;
      stall_mode      = 0;

      build_directed();
      total_bytes = pending_bytes.size();
      build_random();
      total_bytes = pending_bytes.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hold until every byte is in and every value is out, or the idle limit is reached
      while ((accepted_bytes < total_bytes || expected_ints.size() != 0)
             && idle_cycles < IdleLimit)
         @(posedge clock);

      if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
      end else begin
         repeat (DrainCycles) @(posedge clock);
         if (mismatches == 0 && expected_ints.size() == 0)
            $display("== PASS ==");
         else
            $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/csid_pkg.sv
rtl/core/csid_hdr_decode.sv
rtl/core/csid_step.sv
rtl/core/compact_int_stream_decoder_core.sv
dv/tb_top.sv
